// ----- design/psr_pkg.sv -----
`timescale 1ns / 1ps

package psr_pkg;

  // Encoder scaling: speed = floor(enc_delta * SPEED_SCALE / 2^SPEED_SHIFT)
  localparam int SPEED_SCALE       = 65536;
  localparam int SPEED_SHIFT       = 16;
  localparam int FINISH_DRIVE_BAND = 0;

  // Q2.14 target limit (+/-1.0)
  localparam int TARGET_MAX = 16384;

  // Field widths
  localparam int IN_W       = 16;
  localparam int GAIN_W     = 16;
  localparam int MAXI_W     = 30;
  localparam int LIM_W      = 15;
  localparam int DRIVE_W    = 16;
  localparam int CFG_DATA_W = 30;
  localparam int CFG_IDX_W  = 3;

  // Derived datapath widths
  localparam int SCALE_W  = $clog2(SPEED_SCALE + 1) + 1;
  localparam int SPROD_W  = IN_W + SCALE_W;
  localparam int SPEED_W  = SPROD_W - SPEED_SHIFT;
  localparam int TGT_W    = IN_W + 1;
  localparam int ERR_W    = ((SPEED_W > TGT_W) ? SPEED_W : TGT_W) + 1;
  localparam int DIFF_W   = ERR_W + 1;
  localparam int SUM_W    = MAXI_W + 1;
  localparam int SUMX_W   = SUM_W + 1;
  localparam int OPND_W   = SUM_W;
  localparam int PROD_W   = GAIN_W + OPND_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int RAW_W    = ACC_W - 8;
  localparam int CMP_W    = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTEGRAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DRIVE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DRIVE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_BAND   = 3'd7;

  // Multiplier operand select
  localparam logic [1:0] MUL_NONE  = 2'd0;
  localparam logic [1:0] MUL_PROP  = 2'd1;
  localparam logic [1:0] MUL_INTEG = 2'd2;
  localparam logic [1:0] MUL_DERIV = 2'd3;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_prop;
    logic signed [GAIN_W-1:0] gain_integ;
    logic signed [GAIN_W-1:0] gain_deriv;
    logic                     loop_enable;
    logic [MAXI_W-1:0]        max_integral;
    logic [LIM_W-1:0]         max_drive;
    logic [LIM_W-1:0]         min_drive;
    logic [LIM_W-1:0]         error_band;
  } psr_cfg_t;

  typedef struct packed {
    logic       load_in;
    logic       step_err;
    logic [1:0] mul_sel;
    logic       acc_load;
    logic       acc_add;
    logic       out_load;
  } psr_cmd_t;

  typedef struct packed {
    logic out_free;
  } psr_sts_t;

endpackage

// ----- design/pid_speed_regulator.sv -----
`timescale 1ns / 1ps

// PID speed regulator with integral clamp, Q2.14 values and Q8.8 gains.
//
// Input channel (in_*): one transfer per control tick carries the encoder
// delta and the speed target. Result channel (out_*): one transfer per
// input tick carries the drive command and the finish flag.
// Configuration channel (cfg_*): cfg_index selects a register, cfg_data
// holds its value; always ready, write only while no tick is in flight.
//
// The sequencer takes one tick at a time: no new input transfer is accepted
// until the previous result is loaded into the output register. The
// sequence is set by the single 16x31 multiplier, used once for each of the
// proportional, integral and derivative terms, then one accumulate and one
// saturate/deadband step.
// The output register holds a result while the receiver stalls; the next
// tick is accepted meanwhile and its result waits in the final step until
// the register frees up.
// Reset clears the previous error, the error sum and the output valid, and
// loads the register defaults (kp = 1.0, loop disabled).
module pid_speed_regulator (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] enc_delta, [31:16] target_speed
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] drive, [16] finished, [23:17] zero
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [psr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import psr_pkg::*;

  psr_cfg_t cfg_r;
  psr_cmd_t cmd;
  psr_sts_t sts;

  logic signed [DRIVE_W-1:0] out_drive;
  logic                      out_finished;

  // register file: take a write on every cfg transfer
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_prop    <= GAIN_W'(256);
      cfg_r.gain_integ   <= '0;
      cfg_r.gain_deriv   <= '0;
      cfg_r.loop_enable  <= 1'b0;
      cfg_r.max_integral <= MAXI_W'(1048576);
      cfg_r.max_drive    <= LIM_W'(16384);
      cfg_r.min_drive    <= '0;
      cfg_r.error_band   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN_PROP:    cfg_r.gain_prop    <= cfg_data[GAIN_W-1:0];
        REG_GAIN_INTEG:   cfg_r.gain_integ   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_DERIV:   cfg_r.gain_deriv   <= cfg_data[GAIN_W-1:0];
        REG_LOOP_ENABLE:  cfg_r.loop_enable  <= cfg_data[0];
        REG_MAX_INTEGRAL: cfg_r.max_integral <= cfg_data[MAXI_W-1:0];
        REG_MAX_DRIVE:    cfg_r.max_drive    <= cfg_data[LIM_W-1:0];
        REG_MIN_DRIVE:    cfg_r.min_drive    <= cfg_data[LIM_W-1:0];
        REG_ERROR_BAND:   cfg_r.error_band   <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: steps each tick through error update and three multiplies
  psr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic, loop state and output register
  psr_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .cmd          (cmd),
    .sts          (sts),
    .enc_delta    (in_tdata[15:0]),
    .target_speed (in_tdata[31:16]),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_drive    (out_drive),
    .out_finished (out_finished)
  );

  // pack result fields, lowest first, zero pad to whole bytes
  assign out_tdata = {7'd0, out_finished, out_drive};

endmodule

// ----- design/psr_ctrl.sv -----
`timescale 1ns / 1ps

module psr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  psr_pkg::psr_sts_t sts,
  output psr_pkg::psr_cmd_t cmd
);
  import psr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ERR   = 3'd1;
  localparam logic [2:0] ST_MPROP = 3'd2;
  localparam logic [2:0] ST_MINTG = 3'd3;
  localparam logic [2:0] ST_MDERV = 3'd4;
  localparam logic [2:0] ST_ACC   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.step_err = 1'b1;
        state_nxt    = ST_MPROP;
      end
      ST_MPROP: begin
        cmd.mul_sel = MUL_PROP;
        state_nxt   = ST_MINTG;
      end
      ST_MINTG: begin
        cmd.mul_sel  = MUL_INTEG;
        cmd.acc_load = 1'b1;
        state_nxt    = ST_MDERV;
      end
      ST_MDERV: begin
        cmd.mul_sel = MUL_DERIV;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_add = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        // wait for room in the output register
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/psr_dp.sv -----
`timescale 1ns / 1ps

module psr_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  psr_pkg::psr_cfg_t            cfg,
  input  psr_pkg::psr_cmd_t            cmd,
  output psr_pkg::psr_sts_t            sts,
  input  logic signed [psr_pkg::IN_W-1:0] enc_delta,
  input  logic signed [psr_pkg::IN_W-1:0] target_speed,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic signed [psr_pkg::DRIVE_W-1:0] out_drive,
  output logic                         out_finished
);
  import psr_pkg::*;

  localparam logic signed [SCALE_W-1:0] SCALE_S = SCALE_W'(SPEED_SCALE);
  localparam logic signed [TGT_W-1:0]   TGT_HI  = TGT_W'(TARGET_MAX);
  localparam logic signed [TGT_W-1:0]   TGT_LO  = -TGT_W'(TARGET_MAX);
  localparam logic signed [CMP_W-1:0]   FIN_HI  = CMP_W'(FINISH_DRIVE_BAND);
  localparam logic signed [CMP_W-1:0]   FIN_LO  = -CMP_W'(FINISH_DRIVE_BAND);

  // input capture
  logic signed [IN_W-1:0] delta_r, target_r;

  // loop state and per-tick terms
  logic signed [ERR_W-1:0]  err_r, last_err_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [SUM_W-1:0]  sum_r;

  logic signed [SPROD_W-1:0] spd_prod;
  logic signed [SPEED_W-1:0] speed;
  logic signed [TGT_W-1:0]   tgt_ext, tgt_clamp;
  logic signed [ERR_W-1:0]   err_c;
  logic signed [DIFF_W-1:0]  diff_c;
  logic signed [SUMX_W-1:0]  sum_x, sum_lim, sum_c;

  // shared multiplier and accumulator
  logic signed [GAIN_W-1:0] mul_a;
  logic signed [OPND_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  // output stage
  logic signed [RAW_W-1:0]   raw, drv_lim;
  logic signed [DRIVE_W-1:0] drv_sat, drv_c;
  logic signed [CMP_W-1:0]   drv_w, min_w, err_w, band_w;
  logic                      fin_c;
  logic                      out_valid_r, out_fin_r;
  logic signed [DRIVE_W-1:0] out_drive_r;

  // error, difference and clamped sum
  always_comb begin
    spd_prod = SPROD_W'(delta_r) * SPROD_W'(SCALE_S);
    speed    = spd_prod[SPROD_W-1:SPEED_SHIFT];
    tgt_ext  = TGT_W'(target_r);
    if (tgt_ext > TGT_HI) begin
      tgt_clamp = TGT_HI;
    end else if (tgt_ext < TGT_LO) begin
      tgt_clamp = TGT_LO;
    end else begin
      tgt_clamp = tgt_ext;
    end
    // ERR_W stays well under 32 bits, so the 32-bit error limit never bites
    err_c   = ERR_W'(tgt_clamp) - ERR_W'(speed);
    diff_c  = DIFF_W'(err_c) - DIFF_W'(last_err_r);
    sum_x   = SUMX_W'(sum_r) + SUMX_W'(err_c);
    sum_lim = $signed({2'b00, cfg.max_integral});
    if (sum_x > sum_lim) begin
      sum_c = sum_lim;
    end else if (sum_x < -sum_lim) begin
      sum_c = -sum_lim;
    end else begin
      sum_c = sum_x;
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MUL_PROP: begin
        mul_a = cfg.gain_prop;
        mul_b = OPND_W'(err_r);
      end
      MUL_INTEG: begin
        mul_a = cfg.gain_integ;
        mul_b = sum_r;
      end
      MUL_DERIV: begin
        mul_a = cfg.gain_deriv;
        mul_b = OPND_W'(diff_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // floor divide by 256, saturate, deadband, finish test
  always_comb begin
    raw     = acc_r[ACC_W-1:8];
    drv_lim = $signed({{(RAW_W-LIM_W){1'b0}}, cfg.max_drive});
    if (raw > drv_lim) begin
      drv_sat = drv_lim[DRIVE_W-1:0];
    end else if (raw < -drv_lim) begin
      drv_sat = DRIVE_W'(-drv_lim);
    end else begin
      drv_sat = raw[DRIVE_W-1:0];
    end
    drv_w = CMP_W'(drv_sat);
    min_w = $signed({{(CMP_W-LIM_W){1'b0}}, cfg.min_drive});
    if (drv_w < min_w && drv_w > -min_w) begin
      drv_c = '0;
    end else begin
      drv_c = drv_sat;
    end
    err_w  = CMP_W'(err_r);
    band_w = $signed({{(CMP_W-LIM_W){1'b0}}, cfg.error_band});
    fin_c  = (CMP_W'(drv_c) <= FIN_HI) && (CMP_W'(drv_c) >= FIN_LO) &&
             (err_w <= band_w) && (err_w >= -band_w);
  end

  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      delta_r  <= enc_delta;
      target_r <= target_speed;
    end
    if (cmd.step_err) begin
      err_r  <= err_c;
      diff_r <= diff_c;
    end
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (cmd.acc_load) begin
      acc_r <= ACC_W'(prod_r);
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (cmd.out_load) begin
      out_drive_r <= cfg.loop_enable ? drv_c : '0;
      out_fin_r   <= cfg.loop_enable & fin_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r  <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.step_err) begin
        last_err_r <= err_c;
        sum_r      <= sum_c[SUM_W-1:0];
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_drive    = out_drive_r;
  assign out_finished = out_fin_r;

  // the error sum never leaves the integral clamp after a step
  a_sum_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.step_err) |->
      (SUMX_W'(sum_r) <= $signed({2'b00, cfg.max_integral})) &&
      (SUMX_W'(sum_r) >= -$signed({2'b00, cfg.max_integral})))
    else $error("error sum outside integral clamp");

  // a result is loaded only when the output register has room
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result overwrites a waiting transfer");

  // disabled loop yields zero drive and no finish
  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && !cfg.loop_enable) |=> (out_drive_r == '0) && !out_fin_r)
    else $error("disabled loop produced nonzero result");

  // finish implies the drive sits inside its band
  a_fin_band: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fin_r) |->
      (CMP_W'(out_drive_r) <= FIN_HI) && (CMP_W'(out_drive_r) >= FIN_LO))
    else $error("finish raised with drive outside band");

endmodule

// ----- test/pid_speed_regulator_tb.sv -----
`timescale 1ns / 1ps

module pid_speed_regulator_tb;
  import psr_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int RESET_TICKS = 9;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_TICKS = 8;

  // One result transfer, split into its fields.
  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      finished;
  } drive_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // [15:0] enc_delta, [31:16] target_speed

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // [15:0] drive, [16] finished, [23:17] zero

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Ticks waiting for the driver, and drive results waiting for the monitor.
  logic [31:0]   tick_queue[$];
  drive_result_t expected_drives[$];

  // Shadow copy of the regulator settings and loop state, starting at reset values.
  psr_cfg_t reg_shadow = '{gain_prop: 16'sd256, gain_integ: '0, gain_deriv: '0,
                           loop_enable: 1'b0, max_integral: 30'd1048576,
                           max_drive: 15'd16384, min_drive: '0, error_band: '0};
  longint last_err_model = 0;
  longint error_total    = 0;

  int sender_idle_pct = 15;
  int recv_idle_pct   = 50;
  int cruise_target   = 0;

  int n_errors   = 0;
  int n_ticks    = 0;
  int n_results  = 0;
  int n_finished = 0;
  int n_driven   = 0;
  int n_settings = 0;
  int cycle_count = 0;

  pid_speed_regulator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Advance the regulator state by one tick and return the drive it commands.
  // Error and error sum move even with the loop disabled.
  function automatic drive_result_t regulate_tick(input logic [31:0] tick);
    longint delta_v, tgt, err, diff, acc, drv, lim;
    drive_result_t r;
    delta_v = longint'($signed(tick[15:0]));
    tgt = longint'($signed(tick[31:16]));
    if (tgt > TARGET_MAX) tgt = longint'(TARGET_MAX);
    if (tgt < -TARGET_MAX) tgt = -longint'(TARGET_MAX);
    err = tgt - ((delta_v * SPEED_SCALE) >>> SPEED_SHIFT);
    if (err > 64'sd2147483647) err = 64'sd2147483647;
    if (err < -64'sd2147483648) err = -64'sd2147483648;
    diff = err - last_err_model;
    last_err_model = err;
    lim = longint'(reg_shadow.max_integral);
    error_total = error_total + err;
    if (error_total > lim) error_total = lim;
    if (error_total < -lim) error_total = -lim;
    drv = 0;
    r.finished = 1'b0;
    if (reg_shadow.loop_enable) begin
      acc = longint'($signed(reg_shadow.gain_prop)) * err
          + longint'($signed(reg_shadow.gain_integ)) * error_total
          + longint'($signed(reg_shadow.gain_deriv)) * diff;
      drv = acc >>> 8;
      lim = longint'(reg_shadow.max_drive);
      if (drv > lim) drv = lim;
      if (drv < -lim) drv = -lim;
      lim = longint'(reg_shadow.min_drive);
      // deadband: small drive commands collapse to zero
      if (drv < lim && drv > -lim) drv = 0;
      lim = longint'(reg_shadow.error_band);
      r.finished = (drv <= FINISH_DRIVE_BAND && drv >= -FINISH_DRIVE_BAND &&
                    err <= lim && err >= -lim);
    end
    r.drive = drv[DRIVE_W-1:0];
    return r;
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    int g;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: g = $urandom_range(0, 1024) - 512;
      5, 6:          g = $urandom();
      default:       g = 0;
    endcase
    return g[GAIN_W-1:0];
  endfunction

  // Settings for random phase p; the first two hit the register extremes.
  function automatic psr_cfg_t pick_settings(input int p);
    psr_cfg_t c;
    c.gain_prop    = rand_gain();
    c.gain_integ   = rand_gain();
    c.gain_deriv   = rand_gain();
    c.loop_enable  = (p != 5 && p != 9);
    c.max_integral = ($urandom_range(0, 1) != 0) ? MAXI_W'($urandom_range(0, 50000))
                                                 : MAXI_W'($urandom());
    case ($urandom_range(0, 3))
      0:       c.max_drive = 15'd16384;
      1:       c.max_drive = LIM_W'($urandom_range(16385, 32767));
      default: c.max_drive = LIM_W'($urandom_range(0, 16384));
    endcase
    c.min_drive  = ($urandom_range(0, 1) != 0) ? 15'd0 : 15'($urandom_range(0, 3000));
    case ($urandom_range(0, 3))
      0:       c.error_band = '0;
      1:       c.error_band = 15'd32767;
      default: c.error_band = LIM_W'($urandom_range(0, 600));
    endcase
    if (p == 0) begin
      c.gain_prop = 16'h8000; c.gain_integ = 16'h7FFF; c.gain_deriv = 16'h8000;
      c.max_integral = 30'h3FFFFFFF; c.max_drive = '0; c.min_drive = '0;
      c.error_band = 15'd32767;
    end else if (p == 1) begin
      c.gain_prop = 16'h7FFF; c.gain_integ = 16'h8000; c.gain_deriv = 16'h7FFF;
      c.max_integral = '0; c.max_drive = 15'd32767; c.min_drive = 15'd16384;
      c.error_band = '0;
    end
    return c;
  endfunction

  // Mostly a motor tracking a slowly moving target with small speed noise,
  // the rest fully random ticks and out-of-range targets.
  function automatic logic [31:0] make_tick();
    int delta_v, tgt;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      8: begin
        tgt = cruise_target;
        delta_v = tgt;
      end
      9: begin
        tgt = ($urandom_range(0, 1) != 0) ? $urandom_range(16385, 32767)
                                          : -int'($urandom_range(16385, 32768));
        delta_v = $urandom_range(0, 2000) - 1000;
      end
      default: begin
        if ($urandom_range(0, 9) == 0) cruise_target = $urandom_range(0, 32768) - 16384;
        tgt = cruise_target;
        delta_v = tgt + $urandom_range(0, 64) - 32;
      end
    endcase
    return {tgt[15:0], delta_v[15:0]};
  endfunction

  task automatic push_tick(input int delta_v, input int tgt);
    tick_queue.push_back({tgt[15:0], delta_v[15:0]});
  endtask

  // Hold until every queued tick went out and every result came back.
  task automatic wait_drained();
    while (tick_queue.size() != 0 || in_tvalid || expected_drives.size() != 0)
      @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_GAIN_PROP:    reg_shadow.gain_prop    = val[GAIN_W-1:0];
      REG_GAIN_INTEG:   reg_shadow.gain_integ   = val[GAIN_W-1:0];
      REG_GAIN_DERIV:   reg_shadow.gain_deriv   = val[GAIN_W-1:0];
      REG_LOOP_ENABLE:  reg_shadow.loop_enable  = val[0];
      REG_MAX_INTEGRAL: reg_shadow.max_integral = val[MAXI_W-1:0];
      REG_MAX_DRIVE:    reg_shadow.max_drive    = val[LIM_W-1:0];
      REG_MIN_DRIVE:    reg_shadow.min_drive    = val[LIM_W-1:0];
      REG_ERROR_BAND:   reg_shadow.error_band   = val[LIM_W-1:0];
      default: ;
    endcase
  endtask

  // Write every register; call only with the loop drained.
  task automatic load_settings(input psr_cfg_t c);
    write_reg(REG_GAIN_PROP,    CFG_DATA_W'(c.gain_prop));
    write_reg(REG_GAIN_INTEG,   CFG_DATA_W'(c.gain_integ));
    write_reg(REG_GAIN_DERIV,   CFG_DATA_W'(c.gain_deriv));
    write_reg(REG_LOOP_ENABLE,  CFG_DATA_W'(c.loop_enable));
    write_reg(REG_MAX_INTEGRAL, CFG_DATA_W'(c.max_integral));
    write_reg(REG_MAX_DRIVE,    CFG_DATA_W'(c.max_drive));
    write_reg(REG_MIN_DRIVE,    CFG_DATA_W'(c.min_drive));
    write_reg(REG_ERROR_BAND,   CFG_DATA_W'(c.error_band));
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Driver: predict on each input transfer, then present the next tick.
  // A tick already on the bus stays put until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_drives.push_back(regulate_tick(in_tdata));
        n_ticks++;
      end
      if (!in_tvalid || in_tready) begin
        if (tick_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= tick_queue.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest prediction.
  always @(posedge clk) begin
    drive_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (out_tdata[16]) n_finished++;
        if (out_tdata[15:0] != '0) n_driven++;
        if (expected_drives.size() == 0) begin
          $display("%0t: result transfer with nothing expected, got drive %0d finished %0b",
                   $time, $signed(out_tdata[15:0]), out_tdata[16]);
          n_errors++;
        end else begin
          want = expected_drives.pop_front();
          if (out_tdata[15:0] !== want.drive) begin
            $display("%0t: drive mismatch, expected %0d, got %0d",
                     $time, want.drive, $signed(out_tdata[15:0]));
            n_errors++;
          end
          if (out_tdata[16] !== want.finished) begin
            $display("%0t: finished mismatch, expected %0b, got %0b",
                     $time, want.finished, out_tdata[16]);
            n_errors++;
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: a stuck handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d ticks queued and %0d results outstanding",
               $time, tick_queue.size(), expected_drives.size());
      $display("pid_speed_regulator_tb: errors");
      $finish;
    end
  end

  initial begin
    psr_cfg_t c;
    repeat (RESET_TICKS) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Loop disabled at reset: drive and finish stay low while the state runs.
    push_tick(0, 0);
    push_tick(32767, -32768);
    push_tick(-32768, 32767);
    push_tick(100, 200);
    wait_drained();

    // Pure proportional loop at unity gain: target clamp and drive saturation.
    c = '{gain_prop: 16'sd256, gain_integ: '0, gain_deriv: '0, loop_enable: 1'b1,
          max_integral: 30'd1048576, max_drive: 15'd16384, min_drive: '0,
          error_band: '0};
    load_settings(c);
    push_tick(0, 0);
    push_tick(0, 16384);
    push_tick(0, 32767);
    push_tick(0, -32768);
    push_tick(-32768, 32767);
    push_tick(32767, -32768);
    wait_drained();

    // All three terms, integral clamped at zero, drive limit above 1.0, deadband.
    c = '{gain_prop: 16'sd256, gain_integ: 16'sd256, gain_deriv: 16'sd256,
          loop_enable: 1'b1, max_integral: '0, max_drive: 15'd32767,
          min_drive: 15'd1000, error_band: 15'd50};
    load_settings(c);
    push_tick(0, 0);
    push_tick(10, 0);
    push_tick(0, 500);
    push_tick(500, 0);
    push_tick(-32768, 16384);
    push_tick(32767, -16384);
    wait_drained();

    // Random phases: sender idles lightly first, then the receiver, then neither.
    for (int p = 0; p < 12; p++) begin
      if (p == 4) begin
        sender_idle_pct = 50;
        recv_idle_pct   = 15;
      end else if (p == 8) begin
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
      end
      load_settings(pick_settings(p));
      if (p == 6) begin
        // pause the sender mid-phase until every result is back
        repeat (60) tick_queue.push_back(make_tick());
        wait_drained();
        repeat (60) tick_queue.push_back(make_tick());
      end else begin
        repeat (120) tick_queue.push_back(make_tick());
      end
      wait_drained();
    end

    repeat (2 * DRAIN_TICKS) @(posedge clk);
    $display("Ran %0d control ticks under %0d register settings.", n_ticks, n_settings);
    $display("Checked %0d drive results: %0d nonzero, %0d with finish raised.",
             n_results, n_driven, n_finished);
    if (n_errors == 0) begin
      $display("pid_speed_regulator_tb: clean");
    end else begin
      $display("pid_speed_regulator_tb: errors");
    end
    $finish;
  end

endmodule
